// ===== rtl/acf_pkg.sv =====
// Shared types and constants for the ALU with NZCV condition flags.
`timescale 1ns / 1ps

package acf_pkg;

	localparam int ACF_DATA_WIDTH = 32;
	localparam int ACF_WORD_W     = 32;
	localparam int ACF_OP_W       = 4;
	localparam int ACF_SHAMT_W    = 8;

	// input request layout in tdata, lowest bit first
	localparam int ACF_IN_OP_LSB   = 0;
	localparam int ACF_IN_A_LSB    = ACF_IN_OP_LSB + ACF_OP_W;
	localparam int ACF_IN_B_LSB    = ACF_IN_A_LSB + ACF_WORD_W;
	localparam int ACF_IN_SH_LSB   = ACF_IN_B_LSB + ACF_WORD_W;
	localparam int ACF_IN_SF_BIT   = ACF_IN_SH_LSB + ACF_SHAMT_W;
	localparam int ACF_IN_NC_BIT   = ACF_IN_SF_BIT + 1;
	localparam int ACF_IN_USED_W   = ACF_IN_NC_BIT + 1;
	localparam int ACF_IN_TDATA_W  = ((ACF_IN_USED_W + 7) / 8) * 8;

	// output result layout in tdata
	localparam int ACF_OUT_USED_W  = ACF_WORD_W + 4;
	localparam int ACF_OUT_TDATA_W = ((ACF_OUT_USED_W + 7) / 8) * 8;

	typedef enum logic [ACF_OP_W-1:0] {
		OP_XOR  = 4'd0,
		OP_AND  = 4'd1,
		OP_OR   = 4'd2,
		OP_ORN  = 4'd3,
		OP_ANDN = 4'd4,
		OP_ADD  = 4'd5,
		OP_ADC  = 4'd6,
		OP_SUB  = 4'd7,
		OP_SBC  = 4'd8,
		OP_LSL  = 4'd9,
		OP_LSR  = 4'd10,
		OP_ASR  = 4'd11,
		OP_ROR  = 4'd12,
		OP_WRC  = 4'd13
	} acf_op_t;

	typedef struct packed {
		logic v;
		logic c;
		logic z;
		logic n;
	} acf_flags_t;

endpackage

// ===== rtl/acf_shift.sv =====
// Register-controlled shifter and rotator with ARM carry-out rules.
`timescale 1ns / 1ps

module acf_shift import acf_pkg::*; #(
	parameter int DATA_WIDTH = ACF_DATA_WIDTH
) (
	input  acf_op_t                op,
	input  logic [DATA_WIDTH-1:0]  a,
	input  logic [ACF_SHAMT_W-1:0] shamt,
	input  logic                   carry_in,
	output logic [DATA_WIDTH-1:0]  y,
	output logic                   carry
);

	localparam int SW = $clog2(DATA_WIDTH);
	localparam logic [ACF_SHAMT_W-1:0] WIDTH_CNT = ACF_SHAMT_W'(DATA_WIDTH);

	logic [SW-1:0]         sh;
	logic                  cnt_zero;
	logic                  cnt_below;
	logic                  cnt_equal;
	logic [DATA_WIDTH:0]   lsl_ext;
	logic [DATA_WIDTH:0]   lsr_ext;
	logic [DATA_WIDTH:0]   asr_ext;
	logic                  sign;
	logic [DATA_WIDTH-1:0] rot [0:ACF_SHAMT_W];

	// low count bits are exact whenever the count is below the width
	assign sh        = shamt[SW-1:0];
	assign cnt_zero  = (shamt == '0);
	assign cnt_below = (shamt < WIDTH_CNT);
	assign cnt_equal = (shamt == WIDTH_CNT);
	assign sign      = a[DATA_WIDTH-1];

	// one extra bit catches the last bit shifted out
	assign lsl_ext = {1'b0, a} << sh;
	assign lsr_ext = {a, 1'b0} >> sh;
	assign asr_ext = $signed({a, 1'b0}) >>> sh;

	// rotator: count bit i rotates by 2**i modulo the width
	assign rot[0] = a;
	for (genvar i = 0; i < ACF_SHAMT_W; i++) begin : g_rot
		localparam int K = (2 ** i) % DATA_WIDTH;
		if (K == 0) begin : g_id
			assign rot[i+1] = rot[i];
		end else begin : g_step
			assign rot[i+1] = shamt[i] ? {rot[i][K-1:0], rot[i][DATA_WIDTH-1:K]} : rot[i];
		end
	end

	always_comb begin
		y     = a;
		carry = carry_in;
		case (op)
			OP_LSL: begin
				if (cnt_zero) begin
					y = a;
				end else if (cnt_below) begin
					y     = lsl_ext[DATA_WIDTH-1:0];
					carry = lsl_ext[DATA_WIDTH];
				end else begin
					y     = '0;
					carry = cnt_equal & a[0];
				end
			end
			OP_LSR: begin
				if (cnt_zero) begin
					y = a;
				end else if (cnt_below) begin
					y     = lsr_ext[DATA_WIDTH:1];
					carry = lsr_ext[0];
				end else begin
					y     = '0;
					carry = cnt_equal & sign;
				end
			end
			OP_ASR: begin
				if (cnt_zero) begin
					y = a;
				end else if (cnt_below) begin
					y     = asr_ext[DATA_WIDTH:1];
					carry = asr_ext[0];
				end else begin
					y     = {DATA_WIDTH{sign}};
					carry = sign;
				end
			end
			OP_ROR: begin
				if (!cnt_zero) begin
					y     = rot[ACF_SHAMT_W];
					carry = rot[ACF_SHAMT_W][DATA_WIDTH-1];
				end
			end
			default: begin
				y     = a;
				carry = carry_in;
			end
		endcase
	end

endmodule

// ===== rtl/acf_exec.sv =====
// Execute logic: logic ops, adder, shifter select and NZCV flag update.
`timescale 1ns / 1ps

module acf_exec import acf_pkg::*; #(
	parameter int DATA_WIDTH = ACF_DATA_WIDTH
) (
	input  acf_op_t                op,
	input  logic [DATA_WIDTH-1:0]  a,
	input  logic [DATA_WIDTH-1:0]  b,
	input  logic [ACF_SHAMT_W-1:0] shamt,
	input  logic                   set_flags,
	input  logic                   new_carry,
	input  acf_flags_t             flags_in,
	output logic [DATA_WIDTH-1:0]  y,
	output acf_flags_t             flags_out
);

	logic                  is_sub;
	logic [DATA_WIDTH-1:0] b_op;
	logic                  cin;
	logic [DATA_WIDTH:0]   sum;
	logic                  add_v;
	logic [DATA_WIDTH-1:0] sh_y;
	logic                  sh_c;
	logic                  c_nx;
	logic                  v_nx;
	logic                  upd;

	acf_shift #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_shift (
		.op      (op),
		.a       (a),
		.shamt   (shamt),
		.carry_in(flags_in.c),
		.y       (sh_y),
		.carry   (sh_c)
	);

	// subtract is a + ~b + carry-in; C comes out as not-borrow
	assign is_sub = (op inside {OP_SUB, OP_SBC});
	assign b_op   = is_sub ? ~b : b;

	always_comb begin
		case (op)
			OP_ADD:  cin = 1'b0;
			OP_SUB:  cin = 1'b1;
			default: cin = flags_in.c;
		endcase
	end

	assign sum   = {1'b0, a} + {1'b0, b_op} + (DATA_WIDTH + 1)'(cin);
	assign add_v = (a[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]) & (b_op[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]);

	always_comb begin
		y         = '0;
		c_nx      = flags_in.c;
		v_nx      = flags_in.v;
		upd       = 1'b0;
		flags_out = flags_in;
		case (op)
			OP_XOR: begin
				y   = a ^ b;
				upd = set_flags;
			end
			OP_AND: begin
				y   = a & b;
				upd = set_flags;
			end
			OP_OR: begin
				y   = a | b;
				upd = set_flags;
			end
			OP_ORN: begin
				y   = a | ~b;
				upd = set_flags;
			end
			OP_ANDN: begin
				y   = a & ~b;
				upd = set_flags;
			end
			OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
				y    = sum[DATA_WIDTH-1:0];
				c_nx = sum[DATA_WIDTH];
				v_nx = add_v;
				upd  = set_flags;
			end
			OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
				y    = sh_y;
				c_nx = sh_c;
				upd  = set_flags;
			end
			OP_WRC: begin
				// carry write ignores set_flags
				flags_out.c = new_carry;
			end
			default: begin
				y = '0;
			end
		endcase
		if (upd) begin
			flags_out.n = y[DATA_WIDTH-1];
			flags_out.z = (y == '0);
			flags_out.c = c_nx;
			flags_out.v = v_nx;
		end
	end

endmodule

// ===== rtl/alu_with_condition_flags.sv =====
// Top level: input stage, execute logic, result stage and NZCV flag register.
// Path: the input register captures a request, then the result register holds its outcome.
// Throughput: one request per cycle unless the output side stalls; the flag register closes
// a loop through the execute logic, so each request sees the flags of the one before it.
// Stalls on the output side hold both stages; the input side keeps taking requests while
// the input stage is empty or moving. Reset clears both valid bits and all four flags.
`timescale 1ns / 1ps

module alu_with_condition_flags import acf_pkg::*; #(
	parameter int DATA_WIDTH = ACF_DATA_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// operation[3:0], operand_a[35:4], operand_b[67:36], shift_amount[75:68],
	// set_flags[76], new_carry[77], zero fill [79:78]
	input  logic [ACF_IN_TDATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// result[31:0], negative_out[32], zero_out[33], carry_out[34], overflow_out[35],
	// zero fill [39:36]
	output logic [ACF_OUT_TDATA_W-1:0] m_tdata
);

	logic                   valid_s1;
	logic                   valid_s2;
	logic                   adv_s1;
	logic                   take_in;

	acf_op_t                op_s1;
	logic [ACF_WORD_W-1:0]  a_s1;
	logic [ACF_WORD_W-1:0]  b_s1;
	logic [ACF_SHAMT_W-1:0] shamt_s1;
	logic                   set_flags_s1;
	logic                   new_carry_s1;

	logic [DATA_WIDTH-1:0]  y;
	acf_flags_t             flags_nx;
	acf_flags_t             flags_q;
	logic [ACF_WORD_W-1:0]  result_s2;

	assign adv_s1   = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;
	assign take_in  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			flags_q  <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				flags_q  <= flags_nx;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1        <= acf_op_t'(s_tdata[ACF_IN_OP_LSB +: ACF_OP_W]);
			a_s1         <= s_tdata[ACF_IN_A_LSB +: ACF_WORD_W];
			b_s1         <= s_tdata[ACF_IN_B_LSB +: ACF_WORD_W];
			shamt_s1     <= s_tdata[ACF_IN_SH_LSB +: ACF_SHAMT_W];
			set_flags_s1 <= s_tdata[ACF_IN_SF_BIT];
			new_carry_s1 <= s_tdata[ACF_IN_NC_BIT];
		end
		if (adv_s1) begin
			result_s2 <= ACF_WORD_W'(y);
		end
	end

	acf_exec #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_exec (
		.op       (op_s1),
		.a        (DATA_WIDTH'(a_s1)),
		.b        (DATA_WIDTH'(b_s1)),
		.shamt    (shamt_s1),
		.set_flags(set_flags_s1),
		.new_carry(new_carry_s1),
		.flags_in (flags_q),
		.y        (y),
		.flags_out(flags_nx)
	);

	// flag register only changes when a result is loaded, so it matches the held result
	assign m_tvalid = valid_s2;
	assign m_tdata  = {(ACF_OUT_TDATA_W - ACF_OUT_USED_W)'(0),
		flags_q.v, flags_q.c, flags_q.z, flags_q.n, result_s2};

`ifndef SYNTHESIS
	a_flags_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags_q))
		else $error("flags changed without a request moving to the result stage");

	a_flags_hold_noset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !set_flags_s1 && op_s1 != OP_WRC) |=> $stable(flags_q))
		else $error("flags changed on a request without set_flags");

	a_carry_write: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == OP_WRC) |=>
		(flags_q.c == $past(new_carry_s1) && flags_q.n == $past(flags_q.n) &&
		flags_q.z == $past(flags_q.z) && flags_q.v == $past(flags_q.v)))
		else $error("carry write did not update only the carry flag");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready && valid_s1) |-> !s_tready)
		else $error("input taken while both stages are full and stalled");
`endif

endmodule
